// File: design/pqls_pkg.sv
// Package for the linear-scan priority queue.
// Holds the request and status codes, the state encoding and the slot entry layout.
// Depends on nothing; pqls_scan and priority_queue_linear_scan import it.
`default_nettype none

package pqls_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int SLOT_W  = 7;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                live;
		logic [PRIO_W-1:0]   prio;
		logic [VALUE_W-1:0]  value;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

endpackage

`default_nettype wire

// File: design/pqls_scan.sv
// Scan unit of the priority queue: one comparator that visits one slot per cycle.
// Tracks the lowest free slot and the lowest live slot of highest priority.
// Depends on pqls_pkg.
`default_nettype none

module pqls_scan #(
	parameter int CAPACITY = 128,
	parameter int IW       = 7
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pqls_pkg::scan_ctl_t          ctl,
	input  wire  [IW-1:0]                idx,
	input  pqls_pkg::entry_t             entry,
	output logic                         free_found,
	output logic [IW-1:0]                free_idx,
	output logic                         best_found,
	output logic [IW-1:0]                best_idx,
	output logic [pqls_pkg::PRIO_W-1:0]  best_prio,
	output logic [pqls_pkg::VALUE_W-1:0] best_value
);
	import pqls_pkg::*;

	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic                best_found_q;
	logic [IW-1:0]       best_idx_q;
	logic [PRIO_W-1:0]   best_prio_q;
	logic [VALUE_W-1:0]  best_value_q;
	logic                take_free;
	logic                take_best;

	assign take_free = ctl.sample && !entry.live && !free_found_q;
	assign take_best = ctl.sample && entry.live &&
		(!best_found_q || (entry.prio > best_prio_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else if (ctl.clear) begin
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (take_free) begin
				free_found_q <= 1'b1;
			end
			if (take_best) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_free) begin
			free_idx_q <= idx;
		end
		if (take_best) begin
			best_idx_q   <= idx;
			best_prio_q  <= entry.prio;
			best_value_q <= entry.value;
		end
	end

	assign free_found = free_found_q;
	assign free_idx   = free_idx_q;
	assign best_found = best_found_q;
	assign best_idx   = best_idx_q;
	assign best_prio  = best_prio_q;
	assign best_value = best_value_q;

endmodule

`default_nettype wire

// File: design/priority_queue_linear_scan.sv
// Top level of the linear-scan priority queue: slot memory, sequencer and stream ports.
// Depends on pqls_pkg and pqls_scan.
//
// Requests arrive on the slave stream: s_tuser carries the operation (insert,
// delete highest, peek highest), s_tdata the value and priority. Each request
// gives exactly one transaction on the master stream with the status in m_tuser
// and the selected entry and queue flags in m_tdata.
// Slots are held in a single-port-write, single-port-read memory with a
// registered read. Every insert, delete or peek walks the whole memory one slot
// per cycle through one comparator before its result is presented, and s_tready
// returns once the result is loaded; an unused operation code skips the walk
// and goes straight to its result.
// One request is in work at a time and s_tready is low meanwhile.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the following result in the sequencer
// until the register frees.
// After reset the block sweeps the memory to mark every slot free, and s_tready
// stays low during the sweep.
`default_nettype none

module priority_queue_linear_scan #(
	parameter int CAPACITY = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,  // item_value[31:0], item_priority[47:32]
	input  wire  [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,  // out_value[31:0], out_priority[47:32],
	                              // out_slot[54:48], is_empty[55], is_full[56]
	output logic [1:0]  m_tuser   // status[1:0]
);
	import pqls_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	entry_t mem [CAPACITY];

	state_t              state_q, state_n;
	logic [IW:0]         cnt_q, cnt_n;
	logic [CW-1:0]       count_q, count_n;
	op_t                 op_q;
	logic [VALUE_W-1:0]  value_q;
	logic [PRIO_W-1:0]   prio_q;

	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	logic                rd_valid_s1;
	logic [IW-1:0]       rd_idx_s1;
	entry_t              rd_data_s1;

	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	entry_t              wr_data;

	scan_ctl_t           scan_ctl;
	logic                free_found;
	logic [IW-1:0]       free_idx;
	logic                best_found;
	logic [IW-1:0]       best_idx;
	logic [PRIO_W-1:0]   best_prio;
	logic [VALUE_W-1:0]  best_value;

	logic                accept;
	logic                out_load;
	logic [STAT_W-1:0]   res_status;
	logic [VALUE_W-1:0]  res_value;
	logic [PRIO_W-1:0]   res_prio;
	logic [IW-1:0]       res_idx;
	logic [IW+SLOT_W-1:0] res_idx_ext;

	logic                m_tvalid_q;
	logic [STAT_W-1:0]   status_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                is_empty_q;
	logic                is_full_q;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			count_q     <= count_n;
			rd_valid_s1 <= rd_en;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(s_tuser);
			value_q <= s_tdata[31:0];
			prio_q  <= s_tdata[47:32];
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		rd_idx_s1 <= rd_addr;
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (out_load) begin
			status_q    <= res_status;
			out_value_q <= res_value;
			out_prio_q  <= res_prio;
			out_slot_q  <= res_idx_ext[SLOT_W-1:0];
			is_empty_q  <= (count_n == '0);
			is_full_q   <= (count_n == CW'(CAPACITY));
		end
	end

	always_comb begin
		state_n         = state_q;
		cnt_n           = cnt_q;
		count_n         = count_q;
		s_tready        = 1'b0;
		rd_en           = 1'b0;
		rd_addr         = cnt_q[IW-1:0];
		wr_en           = 1'b0;
		wr_addr         = cnt_q[IW-1:0];
		wr_data         = '0;
		scan_ctl.clear  = 1'b0;
		scan_ctl.sample = rd_valid_s1;
		out_load        = 1'b0;
		res_status      = ST_OK;
		res_value       = '0;
		res_prio        = '0;
		res_idx         = '0;

		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				cnt_n = cnt_q + 1'b1;
				if (cnt_q[IW-1:0] == IW'(CAPACITY - 1)) begin
					cnt_n   = '0;
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					scan_ctl.clear = 1'b1;
					cnt_n          = '0;
					if (op_t'(s_tuser) == OP_NONE) begin
						state_n = S_DONE;
					end else begin
						state_n = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (cnt_q != (IW + 1)'(CAPACITY)) begin
					rd_en = 1'b1;
					cnt_n = cnt_q + 1'b1;
				end else if (!rd_valid_s1) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_n  = S_IDLE;
					case (op_q)
						OP_INSERT: begin
							if (free_found) begin
								res_idx       = free_idx;
								wr_en         = 1'b1;
								wr_addr       = free_idx;
								wr_data.live  = 1'b1;
								wr_data.prio  = prio_q;
								wr_data.value = value_q;
								count_n       = count_q + 1'b1;
							end else begin
								res_status = ST_FULL;
							end
						end
						OP_DELETE, OP_PEEK: begin
							if (best_found) begin
								res_value = best_value;
								res_prio  = best_prio;
								res_idx   = best_idx;
								if (op_q == OP_DELETE) begin
									wr_en         = 1'b1;
									wr_addr       = best_idx;
									wr_data.live  = 1'b0;
									wr_data.prio  = best_prio;
									wr_data.value = best_value;
									count_n       = count_q - 1'b1;
								end
							end else begin
								res_status = ST_EMPTY;
							end
						end
						default: begin
							res_status = ST_OK;
						end
					endcase
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

	pqls_scan #(
		.CAPACITY (CAPACITY),
		.IW       (IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (rd_idx_s1),
		.entry      (rd_data_s1),
		.free_found (free_found),
		.free_idx   (free_idx),
		.best_found (best_found),
		.best_idx   (best_idx),
		.best_prio  (best_prio),
		.best_value (best_value)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {7'b0, is_full_q, is_empty_q, out_slot_q, out_prio_q, out_value_q};

endmodule

`default_nettype wire

// File: tb/pqls_checker.sv
// Checker for the linear-scan priority queue: watches both stream channels of the block.
// It keeps its own copy of the slot array, predicts each response and compares it field by field.
// Depends on pqls_pkg for the operation and status codes and the field widths.

module pqls_checker #(
	parameter int CAPACITY = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [47:0] s_tdata,  // item_value[31:0], item_priority[47:32]
	input  wire  [1:0]  s_tuser,  // op[1:0]
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [63:0] m_tdata,  // out_value[31:0], out_priority[47:32],
	                              // out_slot[54:48], is_empty[55], is_full[56]
	input  wire  [1:0]  m_tuser,  // status[1:0]
	output int          mismatches,
	output int          outstanding
);
	import pqls_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
		logic [SLOT_W-1:0]  slot;
		logic               empty;
		logic               full;
	} response_t;

	response_t          pending_responses[$];
	bit                 slot_used [CAPACITY];
	bit [VALUE_W-1:0]   slot_value [CAPACITY];
	bit [PRIO_W-1:0]    slot_prio [CAPACITY];
	int                 used_count;

	function automatic response_t serve_request(op_t op, logic [VALUE_W-1:0] value,
			logic [PRIO_W-1:0] prio);
		response_t r;
		int        pick;
		r    = '0;
		pick = -1;
		case (op)
			OP_INSERT: begin
				for (int k = 0; k < CAPACITY; k++)
					if (pick < 0 && !slot_used[k])
						pick = k;
				if (pick < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_used[pick]  = 1'b1;
					slot_value[pick] = value;
					slot_prio[pick]  = prio;
					used_count++;
					r.slot = SLOT_W'(pick);
				end
			end
			OP_DELETE, OP_PEEK: begin
				for (int k = 0; k < CAPACITY; k++)
					if (slot_used[k] && (pick < 0 || slot_prio[k] > slot_prio[pick]))
						pick = k;
				if (pick < 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = slot_value[pick];
					r.prio  = slot_prio[pick];
					r.slot  = SLOT_W'(pick);
					if (op == OP_DELETE) begin
						slot_used[pick] = 1'b0;
						used_count--;
					end
				end
			end
			default: r.status = ST_OK;
		endcase
		r.empty = (used_count == 0);
		r.full  = (used_count == CAPACITY);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			pending_responses.delete();
			for (int k = 0; k < CAPACITY; k++)
				slot_used[k] = 1'b0;
			used_count = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_responses.size() == 0) begin
					$error("response transaction with no request outstanding");
					mismatches++;
				end else begin
					want = pending_responses.pop_front();
					compare_field("status", 32'(want.status), 32'(m_tuser));
					compare_field("out_value", want.value, m_tdata[31:0]);
					compare_field("out_priority", 32'(want.prio), 32'(m_tdata[47:32]));
					compare_field("out_slot", 32'(want.slot), 32'(m_tdata[54:48]));
					compare_field("is_empty", 32'(want.empty), 32'(m_tdata[55]));
					compare_field("is_full", 32'(want.full), 32'(m_tdata[56]));
				end
			end
			if (s_tvalid && s_tready)
				pending_responses.push_back(serve_request(op_t'(s_tuser), s_tdata[31:0],
					s_tdata[47:32]));
			outstanding <= pending_responses.size();
		end
	end

endmodule

// File: tb/priority_queue_linear_scan_test.sv
// Testbench top for the linear-scan priority queue: clock, reset, request stimulus and verdict.
// Drives directed cases, then fill, drain and mixed random phases with random idling on both sides.
// Depends on pqls_pkg, the block priority_queue_linear_scan and the checker pqls_checker.

module priority_queue_linear_scan_test;
	import pqls_pkg::*;

	localparam int CAPACITY   = 128;
	localparam int ITEM_COUNT = 500;
	localparam int LONG_HOLD  = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	int          mismatches;
	int          outstanding;
	int          depth_est;
	int          sent;
	bit          long_hold_req;
	bit          no_gaps;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	priority_queue_linear_scan #(.CAPACITY(CAPACITY)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	pqls_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic op_t pick_op(int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return OP_NONE;
		if (r < 13)
			return OP_PEEK;
		if (r < 13 + insert_pct * 87 / 100)
			return OP_INSERT;
		return OP_DELETE;
	endfunction

	function automatic logic [15:0] pick_prio();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(1, 6));
		return 16'($urandom_range(1, 65535));
	endfunction

	task automatic offer(op_t op, logic [31:0] value, logic [15:0] prio);
		int gap;
		gap = no_gaps ? 0 : idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {prio, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (op == OP_INSERT && depth_est < CAPACITY)
			depth_est++;
		else if (op == OP_DELETE && depth_est > 0)
			depth_est--;
	endtask

	task automatic drain_all();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	task automatic offer_random(int insert_pct);
		if (sent % 40 == 0)
			no_gaps = ($urandom_range(0, 3) == 0);
		offer(pick_op(insert_pct), $urandom(), pick_prio());
	endtask

	initial begin : receiver
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 300)
						: $urandom_range(1, 8)) @(posedge clk);
				stall = idle_cycles();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int mixed;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_INSERT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		offer(OP_DELETE, 32'h0, 16'h0);
		offer(OP_PEEK, 32'h0, 16'h0);
		offer(OP_NONE, 32'hffff_ffff, 16'hffff);
		offer(OP_INSERT, 32'h7fff_ffff, 16'hffff);
		offer(OP_INSERT, 32'h8000_0000, 16'h0001);
		offer(OP_INSERT, 32'hffff_ffff, 16'hffff);
		offer(OP_INSERT, 32'h0000_0000, 16'h0000);
		offer(OP_PEEK, 32'h0, 16'h0);
		offer(OP_NONE, 32'h0, 16'h0);
		offer(OP_DELETE, 32'h1234_5678, 16'h00ff);
		offer(OP_INSERT, 32'h0000_3039, 16'h0064);
		offer(OP_DELETE, 32'h0, 16'h0);
		offer(OP_PEEK, 32'h0, 16'h0);
		offer(OP_DELETE, 32'h0, 16'h0);
		offer(OP_DELETE, 32'h0, 16'h0);
		offer(OP_DELETE, 32'h0, 16'h0);
		offer(OP_DELETE, 32'h0, 16'h0);
		offer(OP_PEEK, 32'h0, 16'h0);
		drain_all();

		while (depth_est < CAPACITY)
			offer_random(95);
		repeat (3)
			offer(OP_INSERT, $urandom(), pick_prio());
		offer(OP_PEEK, 32'h0, 16'h0);
		offer(OP_NONE, $urandom(), pick_prio());
		drain_all();

		while (depth_est > 0)
			offer_random(5);
		repeat (2)
			offer(OP_DELETE, $urandom(), pick_prio());
		offer(OP_PEEK, 32'h0, 16'h0);
		drain_all();

		mixed = 0;
		while (sent < ITEM_COUNT) begin
			if (mixed == 10)
				long_hold_req = 1'b1;
			offer_random(55);
			mixed++;
		end
		drain_all();
		repeat (2 * CAPACITY) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("priority_queue_linear_scan_test passed");
		else
			$display("priority_queue_linear_scan_test failed");
		$finish;
	end

	initial begin : watchdog
		#8000000;
		$display("priority_queue_linear_scan_test failed");
		$finish;
	end

endmodule
